@@ design/sha256_suffix_work_checker_top_assert.svh @@
// Assertion macros used by the checker's top-level RTL file.
`ifndef SHA256_SUFFIX_WORK_CHECKER_TOP_ASSERT_SVH
`define SHA256_SUFFIX_WORK_CHECKER_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/swc_pkg.sv @@
// Types, constants and functions shared by the proof-of-work checker.
package swc_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_TRY    = 2'd2;

	localparam int RADIX = 62;
	localparam int NIBBLES = 64;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef struct packed {
		logic init;
		logic load;
		logic round;
		logic fold;
		logic [5:0] t;
		logic [7:0] data;
	} swc_ctl_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	// Maps a base-62 digit to digits, then lower case, then upper case.
	function automatic logic [7:0] char_of(input logic [5:0] d);
		if (d < 6'd10)
			char_of = 8'h30 + {2'b00, d};
		else if (d < 6'd36)
			char_of = 8'h61 + {2'b00, d} - 8'd10;
		else
			char_of = 8'h41 + {2'b00, d} - 8'd36;
	endfunction

endpackage

@@ design/swc_wcell.sv @@
// One word cell of the message schedule chain.
module swc_wcell (
	input  logic        clk,
	input  logic        shift_byte,
	input  logic        shift_word,
	input  logic [7:0]  byte_in,
	input  logic [31:0] word_in,
	output logic [31:0] word
);

	logic [31:0] word_q;

	always_ff @(posedge clk) begin
		if (shift_byte)
			word_q <= {word_q[23:0], byte_in};
		else if (shift_word)
			word_q <= word_in;
	end

	assign word = word_q;

endmodule

@@ design/swc_core.sv @@
// SHA-256 compression core: a chain of schedule cells and one round unit.
module swc_core (
	input  logic             clk,
	input  swc_pkg::swc_ctl_t ctl,
	output logic [255:0]     digest
);

	logic [31:0] w [16];
	logic [31:0] w_new;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] mj;

	for (genvar i = 0; i < 16; i++) begin : g_cell
		logic [7:0]  nb;
		logic [31:0] nw;
		if (i == 15) begin : g_last
			assign nb = ctl.data;
			assign nw = w_new;
		end else begin : g_mid
			assign nb = w[i + 1][31:24];
			assign nw = w[i + 1];
		end
		swc_wcell u_cell (
			.clk        (clk),
			.shift_byte (ctl.load),
			.shift_word (ctl.round),
			.byte_in    (nb),
			.word_in    (nw),
			.word       (w[i])
		);
	end

	assign w_new = w[0] + swc_pkg::small_s0(w[1]) + w[9] + swc_pkg::small_s1(w[14]);

	always_comb begin
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + swc_pkg::big_s1(v_q[4]) + ch + swc_pkg::ROUND_K[ctl.t] + w[0];
		t2 = swc_pkg::big_s0(v_q[0]) + mj;
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= swc_pkg::INIT_H[i];
				v_q[i] <= swc_pkg::INIT_H[i];
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
				v_q[i] <= h_q[i] + v_q[i];
			end
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign digest = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

endmodule

@@ design/swc_nonce.sv @@
// Base-62 converter that produces the nonce digits, sixteen counter bits per cycle.
module swc_nonce #(
	parameter int NONCE_DIGITS = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [63:0]                          value,
	output logic                                 fin,
	output logic [$clog2(NONCE_DIGITS+1)-1:0]    count,
	output logic [NONCE_DIGITS-1:0][5:0]         digits
);

	localparam int CW = $clog2(NONCE_DIGITS + 1);
	localparam logic [21:0] RADIX22 = 22'(swc_pkg::RADIX);
	// Rounded-up reciprocal of 31 scaled by two to the 26th.
	localparam logic [21:0] RECIP31 = 22'd2164803;

	logic                        busy_q;
	logic [1:0]                  chunk_q;
	logic [CW-1:0]               n_q;
	logic [63:0]                 v_q;
	logic [47:0]                 quo_q;
	logic [5:0]                  rem_q;
	logic [NONCE_DIGITS-1:0][5:0] digits_q;
	logic [21:0]                 x;
	logic [42:0]                 prod;
	logic [15:0]                 qd;
	logic [21:0]                 rem_w;
	logic [5:0]                  rem_n;
	logic [63:0]                 quo;
	logic                        last;
	logic                        stop;

	always_comb begin
		x = {rem_q, v_q[63:48]};
		prod = 43'(x[21:1]) * 43'(RECIP31);
		qd = prod[41:26];
		rem_w = x - 22'(qd) * RADIX22;
		rem_n = rem_w[5:0];
		quo = {quo_q, qd};
		last = busy_q && (chunk_q == 2'd3);
		stop = (quo == 64'd0) || (n_q + CW'(1) == CW'(NONCE_DIGITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chunk_q <= '0;
			n_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			chunk_q <= '0;
			n_q <= '0;
		end else if (busy_q) begin
			chunk_q <= chunk_q + 2'd1;
			if (last) begin
				n_q <= n_q + CW'(1);
				if (stop)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			quo_q <= '0;
			rem_q <= '0;
			digits_q <= '0;
		end else if (busy_q) begin
			if (last) begin
				v_q <= quo;
				quo_q <= '0;
				rem_q <= '0;
				for (int i = 0; i < NONCE_DIGITS; i++) begin
					if (n_q == CW'(i))
						digits_q[i] <= rem_n;
				end
			end else begin
				v_q <= {v_q[47:0], 16'h0000};
				quo_q <= {quo_q[31:0], qd};
				rem_q <= rem_n;
			end
		end
	end

	assign fin = last && stop;
	assign count = n_q;
	assign digits = digits_q;

endmodule

@@ design/sha256_suffix_work_checker_top.sv @@
// Top level of the SHA-256 suffix proof-of-work checker.
// Items enter on in_valid/in_stall with command, prefix_byte and counter.
// A clear or append item is taken in the idle state and yields no result.
// A try item turns counter into a base-62 nonce, hashes prefix, space and
// nonce, and yields one result on out_valid/out_stall.
// The strength register is written on cfg_valid/cfg_ready; the user must
// write it only while idle, the block itself does not enforce it.
// A try runs in steps: the converter makes the nonce digits, a planning
// step follows, then each 64-byte block loads the schedule chain, runs 64
// rounds and ends in one fold; 1 to 3 blocks at the default sizes. Last
// come the nibble scan and the load of the output register.
// One try is in flight at a time; in_stall is high while it runs, so no new
// item is taken before it ends, and the single round unit sets most of it.
// A result waits in the output register while out_stall is high; clear and
// append items are still taken meanwhile, and a new try runs but holds its
// result until the register is free.
// Reset empties the prefix, clears the overflow flag and sets strength to 0.
module sha256_suffix_work_checker_top #(
	parameter int PREFIX_MAX = 128,
	parameter int NONCE_DIGITS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          command,
	input  logic [7:0]                          prefix_byte,
	input  logic [63:0]                         counter,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                meets_strength,
	output logic [6:0]                          zero_nibbles,
	output logic [8*NONCE_DIGITS-1:0]           nonce_chars,
	output logic [$clog2(NONCE_DIGITS+1)-1:0]   nonce_length,
	output logic                                prefix_overflowed,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [6:0]                          cfg_data
);

	`include "sha256_suffix_work_checker_top_assert.svh"

	localparam int AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
	localparam int LW = $clog2(PREFIX_MAX + 1);
	localparam int MSG_MAX = ((PREFIX_MAX + 1 + NONCE_DIGITS + 9 + 63) / 64) * 64;
	localparam int PW = $clog2(MSG_MAX + 1);
	localparam int CW = $clog2(NONCE_DIGITS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_NONCE = 3'd1;
	localparam logic [2:0] ST_PLAN  = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_FOLD  = 3'd5;
	localparam logic [2:0] ST_SCAN  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]                   state_q;
	logic [6:0]                   strength_q;
	logic [LW-1:0]                plen_q;
	logic                         ovf_q;
	logic [PW-1:0]                pos_q;
	logic [PW-1:0]                end_q;
	logic [PW-1:0]                mlen_q;
	logic [5:0]                   round_q;
	logic [6:0]                   zn_q;
	logic                         scan_ld_q;
	logic [255:0]                 dsh_q;
	logic [7:0]                   mem_q [PREFIX_MAX];
	logic [7:0]                   rd_q;
	logic                         out_valid_q;
	logic                         meets_q;
	logic [6:0]                   zn_out_q;
	logic [8*NONCE_DIGITS-1:0]    chars_q;
	logic [CW-1:0]                nlen_q;
	logic                         ovf_out_q;

	logic                         accept;
	logic                         try_go;
	logic                         nonce_fin;
	logic [CW-1:0]                ncount;
	logic [NONCE_DIGITS-1:0][5:0] ndigits;
	logic [255:0]                 digest;
	swc_pkg::swc_ctl_t            ctl;
	logic [PW-1:0]                rd_addr;
	logic [PW-1:0]                plen_p;
	logic [PW-1:0]                didx;
	logic [PW-1:0]                kidx;
	logic [63:0]                  lbits;
	logic [7:0]                   msg_byte;
	logic [5:0]                   dsel;
	logic [PW:0]                  tot;
	logic [8*NONCE_DIGITS-1:0]    chars_n;
	logic                         out_free;

	assign accept = in_valid && !in_stall;
	assign try_go = accept && (command == swc_pkg::CMD_TRY);
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;

	swc_nonce #(
		.NONCE_DIGITS (NONCE_DIGITS)
	) u_nonce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (try_go),
		.value  (counter),
		.fin    (nonce_fin),
		.count  (ncount),
		.digits (ndigits)
	);

	always_comb begin
		plen_p = PW'(plen_q);
		didx = mlen_q - PW'(1) - pos_q;
		kidx = end_q - PW'(1) - pos_q;
		lbits = 64'(mlen_q) << 3;
		dsel = '0;
		for (int i = 0; i < NONCE_DIGITS; i++) begin
			if (didx == PW'(i))
				dsel = ndigits[i];
		end
		if (pos_q < plen_p)
			msg_byte = rd_q;
		else if (pos_q == plen_p)
			msg_byte = swc_pkg::CHAR_SPACE;
		else if (pos_q < mlen_q)
			msg_byte = swc_pkg::char_of(dsel);
		else if (pos_q == mlen_q)
			msg_byte = swc_pkg::PAD_BYTE;
		else if ((end_q - pos_q) <= PW'(8))
			msg_byte = lbits[{kidx[2:0], 3'b000} +: 8];
		else
			msg_byte = 8'h00;
	end

	always_comb begin
		ctl.init = try_go;
		ctl.load = (state_q == ST_LOAD);
		ctl.round = (state_q == ST_ROUND);
		ctl.fold = (state_q == ST_FOLD);
		ctl.t = round_q;
		ctl.data = msg_byte;
	end

	swc_core u_core (
		.clk    (clk),
		.ctl    (ctl),
		.digest (digest)
	);

	assign rd_addr = (state_q == ST_LOAD) ? pos_q + PW'(1) : pos_q;
	assign tot = (PW+1)'(mlen_q) + (PW+1)'(72);

	always_ff @(posedge clk) begin
		if (accept && command == swc_pkg::CMD_APPEND && plen_q < LW'(PREFIX_MAX))
			mem_q[plen_q[AW-1:0]] <= prefix_byte;
		rd_q <= mem_q[rd_addr[AW-1:0]];
	end

	always_comb begin
		chars_n = '0;
		for (int i = 0; i < NONCE_DIGITS; i++) begin
			if (CW'(i) < ncount)
				chars_n[8*i +: 8] = swc_pkg::char_of(ndigits[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strength_q <= '0;
			plen_q <= '0;
			ovf_q <= 1'b0;
			pos_q <= '0;
			round_q <= '0;
			zn_q <= '0;
			scan_ld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				strength_q <= cfg_data;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command)
							swc_pkg::CMD_CLEAR: begin
								plen_q <= '0;
								ovf_q <= 1'b0;
							end
							swc_pkg::CMD_APPEND: begin
								if (plen_q < LW'(PREFIX_MAX))
									plen_q <= plen_q + LW'(1);
								else
									ovf_q <= 1'b1;
							end
							swc_pkg::CMD_TRY: begin
								pos_q <= '0;
								state_q <= ST_NONCE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_NONCE: begin
					if (nonce_fin)
						state_q <= ST_PLAN;
				end
				ST_PLAN: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					pos_q <= pos_q + PW'(1);
					if (pos_q[5:0] == 6'd63) begin
						round_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63)
						state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					if (pos_q == end_q) begin
						scan_ld_q <= 1'b1;
						zn_q <= '0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_SCAN: begin
					scan_ld_q <= 1'b0;
					if (!scan_ld_q) begin
						if (zn_q == 7'(swc_pkg::NIBBLES) || dsh_q[3:0] != 4'h0)
							state_q <= ST_DONE;
						else
							zn_q <= zn_q + 7'd1;
					end
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PLAN) begin
			mlen_q <= plen_p + PW'(1) + PW'(ncount);
		end
		if (state_q == ST_LOAD && pos_q == '0) begin
			end_q <= PW'({tot[PW:6], 6'b000000});
		end
		if (state_q == ST_SCAN) begin
			if (scan_ld_q)
				dsh_q <= digest;
			else
				dsh_q <= {4'h0, dsh_q[255:4]};
		end
		if (state_q == ST_DONE && out_free) begin
			meets_q <= zn_q >= strength_q;
			zn_out_q <= zn_q;
			chars_q <= chars_n;
			nlen_q <= ncount;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign meets_strength = meets_q;
	assign zero_nibbles = zn_out_q;
	assign nonce_chars = chars_q;
	assign nonce_length = nlen_q;
	assign prefix_overflowed = ovf_out_q;

	`SWC_ASSERT_NEXT(a_try_starts_nonce, clk, arst_n, try_go, state_q == ST_NONCE,
		"A try item did not start the nonce converter.")
	`SWC_ASSERT_NEXT(a_round_end_folds, clk, arst_n,
		state_q == ST_ROUND && round_q == 6'd63, state_q == ST_FOLD,
		"The last round was not followed by the fold step.")
	`SWC_ASSERT_NOW(a_prefix_bound, clk, arst_n, 1'b1, plen_q <= LW'(PREFIX_MAX),
		"The prefix length passed the store size.")
	`SWC_ASSERT_NOW(a_scan_bound, clk, arst_n, state_q == ST_SCAN,
		zn_q <= 7'(swc_pkg::NIBBLES), "The zero nibble count passed the digest size.")

endmodule
